@@ hdl/dlc_pkg.sv @@
// Shared types and constants for the decibel level converter.
// Request/response payload structs, operation codes, fixed-point scale constants.
package dlc_pkg;

	typedef enum logic [1:0] {
		OP_POW2DB = 2'd0,
		OP_RMS2DB = 2'd1,
		OP_DB2POW = 2'd2,
		OP_DB2RMS = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        saturated;
	} rsp_t;

	// log2 -> dB scale factors, Q.32
	localparam logic [34:0] TEN_LOG10_2_Q32    = 35'd12929139865;
	localparam logic [34:0] TWENTY_LOG10_2_Q32 = 35'd25858279730;
	// dB -> log2 scale factors, Q.32
	localparam logic [30:0] LOG2_10_DIV10_Q32  = 31'd1426757253;
	localparam logic [30:0] LOG2_10_DIV20_Q32  = 31'd713378626;
	localparam logic [31:0] LN2_Q32            = 32'd2977044472;

	localparam int unsigned LOG_ITERS = 24;
	localparam int unsigned EXP_TERMS = 16;
	localparam int unsigned CLAMP_POW_DB = 870;
	localparam int unsigned CLAMP_RMS_DB = 485;
	localparam int unsigned REF_DB       = 100;

endpackage

@@ hdl/decibel_level_converter.sv @@
// Decibel level converter, top level: fully pipelined linear <-> dB conversion.
// Depends on dlc_pkg (payload structs, op codes, scale constants).
//
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries an op code and a
//   32-bit operand; response channel (rsp_valid/rsp_ready/rsp_data) returns the
//   converted value and a saturation flag, one response per request, in order.
//   Ops: power->dB and rms->dB (100 dB reference, Q8.LIN in, Q.DB out),
//   dB->power and dB->rms (Q.DB in, Q8.LIN out, clamped inputs).
//
// Timing:
//   One request is taken per cycle while the response is not held. The
//   depth comes from the exp side: one stage to scale the dB value, one to
//   form the series argument, and two multiplier stages per term of the
//   16-term exp series (product, then exact reciprocal division by k). The
//   log side runs 24 squaring stages in parallel and waits at the end.
//
// Stall / reset:
//   When the response is held (rsp_valid high, rsp_ready low) every stage
//   freezes and req_ready drops; bubbles are not squeezed out. Reset clears
//   all stage valid bits; data registers are not reset.
module decibel_level_converter
	import dlc_pkg::*;
#(
	parameter int LIN_FRAC_BITS = 24,
	parameter int DB_FRAC_BITS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	localparam int NST  = 36;               // pipeline depth
	localparam int TW   = 10 + DB_FRAC_BITS; // clamped dB operand width
	localparam int EW   = TW + 31;           // scaled exponent product width
	localparam logic [TW-1:0] LIM_POW = TW'(CLAMP_POW_DB << DB_FRAC_BITS);
	localparam logic [TW-1:0] LIM_RMS = TW'(CLAMP_RMS_DB << DB_FRAC_BITS);
	localparam logic [TW-1:0] REF_FX  = TW'(REF_DB << DB_FRAC_BITS);
	localparam logic [EW-1:0] E_HALF  =
		(DB_FRAC_BITS > 0) ? EW'(1) << (DB_FRAC_BITS - 1) : '0;
	localparam logic [41:0]   DB_HALF = 42'd1 << (31 - DB_FRAC_BITS);
	localparam logic [40:0]   BASE_DB = 41'd100 << 32;

	// pipeline registers, one entry per stage
	logic [NST:1]          vld_s;
	op_t                   op_s    [1:NST];
	logic                  zero_s  [1:NST];
	// log side
	logic [31:0]           ly_s    [1:NST];
	logic [4:0]            lp_s    [1:NST];
	logic [23:0]           lfrac_s [1:NST];
	logic                  lneg_s  [1:NST];
	logic [39:0]           ld_s    [1:NST];
	logic [31:0]           ldb_s   [1:NST];
	// exp side
	logic                  eneg_s  [1:NST];
	logic [TW-1:0]         et_s    [1:NST];
	logic signed [10:0]    en_s    [1:NST];
	logic [31:0]           ef_s    [1:NST];
	logic [31:0]           ex_s    [1:NST];
	logic [32:0]           eterm_s [1:NST];
	logic [31:0]           eprod_s [1:NST];
	logic [33:0]           esum_s  [1:NST];
	// output
	logic [31:0]           res_s   [1:NST];
	logic                  sat_s   [1:NST];

	logic adv;

	// whole pipe moves unless the response is being held
	assign adv       = !rsp_valid || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = vld_s[NST];
	assign rsp_data  = '{result: res_s[NST], saturated: sat_s[NST]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-1:1], req_valid};
		end
	end

	// ---------------- stage 1: normalize / clamp ----------------
	logic [4:0]    in_p;
	logic [TW-1:0] in_lim;
	logic [TW-1:0] in_d;
	logic          in_neg;

	always_comb begin
		in_p = '0;
		for (int i = 0; i < 32; i++) begin
			if (req_data.value[i]) begin
				in_p = 5'(i);
			end
		end
		in_lim = (req_data.op == OP_DB2RMS) ? LIM_RMS : LIM_POW;
		in_d   = (req_data.value > 32'(in_lim)) ? in_lim : TW'(req_data.value);
		in_neg = in_d < REF_FX;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s[1]    <= req_data.op;
			zero_s[1]  <= (req_data.value == '0);
			lp_s[1]    <= in_p;
			ly_s[1]    <= req_data.value << (5'd31 - in_p);
			lfrac_s[1] <= '0;
			lneg_s[1]  <= 1'b0;
			ld_s[1]    <= '0;
			ldb_s[1]   <= '0;
			eneg_s[1]  <= in_neg;
			et_s[1]    <= in_neg ? REF_FX - in_d : in_d - REF_FX;
			en_s[1]    <= '0;
			ef_s[1]    <= '0;
			ex_s[1]    <= '0;
			eterm_s[1] <= '0;
			eprod_s[1] <= '0;
			esum_s[1]  <= '0;
			res_s[1]   <= '0;
			sat_s[1]   <= 1'b0;
		end
	end

	// ---------------- stages 2..NST ----------------
	for (genvar j = 2; j <= NST; j++) begin : g_stage
		// series term index handled by this stage (stages 4..35)
		localparam int K  = (j - 2) / 2;
		localparam int KD = (K > 0) ? K : 1;
		localparam int LK = (KD > 1) ? $clog2(KD) : 0;
		// exact floor(n/K) for 32-bit n: (n * MK) >> (32 + LK)
		localparam logic [65:0] MK =
			((66'd1 << (32 + LK)) + 66'(KD) - 66'd1) / 66'(KD);

		logic [31:0]        ly_n, ldb_n, ef_n, ex_n, eprod_n, res_n;
		logic [23:0]        lfrac_n;
		logic               lneg_n, sat_n;
		logic [39:0]        ld_n;
		logic signed [10:0] en_n;
		logic [32:0]        eterm_n;
		logic [33:0]        esum_n;
		// scratch
		logic [63:0]        sq;
		logic [33:0]        sqr;
		logic [EW-1:0]      ep;
		logic [8:0]         ip;
		logic [31:0]        fr;
		logic [63:0]        xp;
		logic [64:0]        tp;
		logic [65:0]        qp;
		logic signed [31:0] pe, lgv;
		logic [28:0]        la;
		logic [34:0]        kk;
		logic [63:0]        dm;
		logic [40:0]        db;
		logic signed [11:0] sh_s;
		logic [5:0]         sh;
		logic [64:0]        rr;

		always_comb begin
			ly_n    = ly_s[j-1];
			lfrac_n = lfrac_s[j-1];
			lneg_n  = lneg_s[j-1];
			ld_n    = ld_s[j-1];
			ldb_n   = ldb_s[j-1];
			en_n    = en_s[j-1];
			ef_n    = ef_s[j-1];
			ex_n    = ex_s[j-1];
			eterm_n = eterm_s[j-1];
			eprod_n = eprod_s[j-1];
			esum_n  = esum_s[j-1];
			res_n   = res_s[j-1];
			sat_n   = sat_s[j-1];
			sq = '0; sqr = '0; ep = '0; ip = '0; fr = '0; xp = '0; tp = '0; qp = '0;
			pe = '0; lgv = '0; la = '0; kk = '0; dm = '0; db = '0;
			sh_s = '0; sh = '0; rr = '0;

			// log2 by repeated squaring, one fraction bit per stage
			if (j <= 1 + LOG_ITERS) begin
				sq  = 64'(ly_s[j-1]) * 64'(ly_s[j-1]);
				sqr = 34'((sq + (64'd1 << 30)) >> 31);
				if (sqr[33:32] != 2'b00) begin
					lfrac_n = {lfrac_s[j-1][22:0], 1'b1};
					ly_n    = sqr[32:1];
				end else begin
					lfrac_n = {lfrac_s[j-1][22:0], 1'b0};
					ly_n    = sqr[31:0];
				end
			end

			// log2 -> dB offset
			if (j == 2 + LOG_ITERS) begin
				pe     = $signed({27'd0, lp_s[j-1]}) - signed'(32'(LIN_FRAC_BITS));
				lgv    = (pe <<< 24) + $signed({8'd0, lfrac_s[j-1]});
				lneg_n = lgv[31];
				la     = lgv[31] ? 29'(-lgv) : 29'(lgv);
				kk     = (op_s[j-1] == OP_RMS2DB) ? TWENTY_LOG10_2_Q32 : TEN_LOG10_2_Q32;
				dm     = 64'(la) * 64'(kk) + (64'd1 << 23);
				ld_n   = 40'(dm >> 24);
			end

			// add 100 dB reference, round to output format
			if (j == 3 + LOG_ITERS) begin
				if (lneg_s[j-1]) begin
					db = BASE_DB - 41'(ld_s[j-1]);
				end else begin
					db = BASE_DB + 41'(ld_s[j-1]);
				end
				if (lneg_s[j-1] && (41'(ld_s[j-1]) >= BASE_DB)) begin
					ldb_n = '0;
				end else begin
					ldb_n = 32'((42'(db) + DB_HALF) >> (32 - DB_FRAC_BITS));
				end
			end

			// dB -> exponent: integer part and Q.32 fraction
			if (j == 2) begin
				ep = EW'(et_s[j-1]) * EW'((op_s[j-1] == OP_DB2RMS) ?
					LOG2_10_DIV20_Q32 : LOG2_10_DIV10_Q32) + E_HALF;
				ip = 9'(ep >> (DB_FRAC_BITS + 32));
				fr = 32'(ep >> DB_FRAC_BITS);
				if (!eneg_s[j-1]) begin
					en_n = 11'($signed({2'b00, ip}));
					ef_n = fr;
				end else if (fr == '0) begin
					en_n = 11'sd0 - 11'($signed({2'b00, ip}));
					ef_n = '0;
				end else begin
					en_n = 11'sd0 - 11'($signed({2'b00, ip})) - 11'sd1;
					ef_n = 32'(-fr);
				end
			end

			// series argument x = f * ln2
			if (j == 3) begin
				xp      = 64'(ef_s[j-1]) * 64'(LN2_Q32) + (64'd1 << 31);
				ex_n    = 32'(xp >> 32);
				eterm_n = 33'd1 << 32;
				esum_n  = 34'd1 << 32;
			end

			// series terms: even stage multiplies by x, odd stage divides by k
			if (j >= 4 && j <= 3 + 2 * EXP_TERMS) begin
				if (j % 2 == 0) begin
					tp      = 65'(eterm_s[j-1]) * 65'(ex_s[j-1]);
					eprod_n = 32'(tp >> 32);
				end else begin
					qp      = 66'(eprod_s[j-1]) * MK;
					eterm_n = 33'(qp >> (32 + LK));
					esum_n  = esum_s[j-1] + 34'(eterm_n);
				end
			end

			// final select, scale and saturate
			if (j == NST) begin
				sat_n = 1'b0;
				if (zero_s[j-1]) begin
					res_n = '0;
				end else if (op_s[j-1] == OP_POW2DB || op_s[j-1] == OP_RMS2DB) begin
					res_n = ldb_s[j-1];
				end else begin
					sh_s = 12'(en_s[j-1]) + 12'(LIN_FRAC_BITS) - 12'sd32;
					if (!sh_s[11]) begin
						res_n = '1;
						sat_n = 1'b1;
					end else if (sh_s <= -12'sd64) begin
						res_n = '0;
					end else begin
						sh = 6'(-sh_s);
						rr = (65'(esum_s[j-1]) + (65'd1 << (sh - 6'd1))) >> sh;
						if (rr[64:32] != '0) begin
							res_n = '1;
							sat_n = 1'b1;
						end else begin
							res_n = rr[31:0];
						end
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				op_s[j]    <= op_s[j-1];
				zero_s[j]  <= zero_s[j-1];
				lp_s[j]    <= lp_s[j-1];
				eneg_s[j]  <= eneg_s[j-1];
				et_s[j]    <= et_s[j-1];
				ly_s[j]    <= ly_n;
				lfrac_s[j] <= lfrac_n;
				lneg_s[j]  <= lneg_n;
				ld_s[j]    <= ld_n;
				ldb_s[j]   <= ldb_n;
				en_s[j]    <= en_n;
				ef_s[j]    <= ef_n;
				ex_s[j]    <= ex_n;
				eterm_s[j] <= eterm_n;
				eprod_s[j] <= eprod_n;
				esum_s[j]  <= esum_n;
				res_s[j]   <= res_n;
				sat_s[j]   <= sat_n;
			end
		end
	end

endmodule

@@ verif/decibel_level_converter_test.sv @@
// Testbench for decibel_level_converter: directed table, then random requests,
// checked in order against typed-in values or an in-bench fixed-point predictor.
// Depends on dlc_pkg and the decibel_level_converter RTL.
module decibel_level_converter_test
	import dlc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIN_FB = 24;
	localparam int DB_FB  = 8;
	localparam int N_RAND = 850;
	localparam int LAT    = 36;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;

	decibel_level_converter i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idling phases: 0 sender 17% / receiver 48%, 1 swapped, 2 none.
	int phase = 0;
	int hold_cycles = 0;   // long receiver hold-off, counted down at clk
	int errors = 0;
	int mismatches = 0;
	bit stim_done = 1'b0;
	rsp_t level_q[$];      // expected responses, oldest first

	// Log side: linear Q8.24 -> dB Q.8, k scales log2 to dB in Q.32.
	function automatic logic [31:0] lin2db(logic [31:0] v, logic [63:0] k);
		int p;
		logic [63:0] y, frac, a, d, db, base;
		longint lg;
		base = 64'd100 << 32;
		frac = 0;
		if (v == 0)
			return 0;
		p = 31;
		while (v[p] == 1'b0)
			p--;
		y = 64'(v) << (31 - p);
		for (int i = 0; i < 24; i++) begin
			y = (y * y + (64'd1 << 30)) >> 31;
			frac = frac << 1;
			if (y >= (64'd1 << 32)) begin
				frac[0] = 1'b1;
				y = y >> 1;
			end
		end
		lg = longint'(p - LIN_FB) * (longint'(1) << 24) + longint'(frac);
		a = lg < 0 ? 64'(-lg) : 64'(lg);
		d = (a * k + (64'd1 << 23)) >> 24;
		if (lg < 0) begin
			if (d >= base)
				return 0;
			db = base - d;
		end else begin
			db = base + d;
		end
		db = (db + (64'd1 << (31 - DB_FB))) >> (32 - DB_FB);
		return db[31:0];
	endfunction

	function automatic logic [63:0] exp2_series(logic [63:0] f);
		logic [63:0] x, term, sum;
		x = (f * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
		term = 64'd1 << 32;
		sum = term;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * x) >> 32) / k;
			sum += term;
		end
		return sum;
	endfunction

	function automatic rsp_t db2lin(logic [31:0] v, int clamp_db, logic [63:0] c);
		rsp_t r;
		logic [63:0] d, lim, ref_db, t, e, fr, f, m, q;
		longint ip, n, s;
		bit neg;
		r = '0;
		if (v == 0)
			return r;
		d = v;
		lim = 64'(clamp_db) << DB_FB;
		ref_db = 64'd100 << DB_FB;
		if (d > lim)
			d = lim;
		neg = d < ref_db;
		t = neg ? ref_db - d : d - ref_db;
		e = (t * c + (64'd1 << (DB_FB - 1))) >> DB_FB;
		ip = longint'(e >> 32);
		fr = e & 64'hFFFF_FFFF;
		if (!neg) begin
			n = ip; f = fr;
		end else if (fr == 0) begin
			n = -ip; f = 0;
		end else begin
			n = -ip - 1; f = (64'd1 << 32) - fr;
		end
		m = exp2_series(f);
		s = n + LIN_FB - 32;
		if (s >= 0) begin
			r.result = '1; r.saturated = 1'b1;
			return r;
		end
		if (s <= -64)
			return r;
		q = (m + (64'd1 << (-s - 1))) >> (-s);
		if (q > 64'hFFFF_FFFF) begin
			r.result = '1; r.saturated = 1'b1;
		end else begin
			r.result = q[31:0];
		end
		return r;
	endfunction

	function automatic rsp_t convert_level(req_t rq);
		rsp_t r;
		r = '0;
		case (rq.op)
			OP_POW2DB: r.result = lin2db(rq.value, 64'(TEN_LOG10_2_Q32));
			OP_RMS2DB: r.result = lin2db(rq.value, 64'(TWENTY_LOG10_2_Q32));
			OP_DB2POW: r = db2lin(rq.value, CLAMP_POW_DB, 64'(LOG2_10_DIV10_Q32));
			default:   r = db2lin(rq.value, CLAMP_RMS_DB, 64'(LOG2_10_DIV20_Q32));
		endcase
		return r;
	endfunction

	// Directed table; use_typed marks rows whose response is typed in.
	typedef struct {
		op_t         op;
		logic [31:0] value;
		bit          use_typed;
		logic [31:0] result;
		logic        saturated;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{OP_POW2DB, 32'h0000_0000, 1, 32'd0, 1'b0},          // zero operand
		'{OP_RMS2DB, 32'h0000_0000, 1, 32'd0, 1'b0},
		'{OP_DB2POW, 32'h0000_0000, 1, 32'd0, 1'b0},
		'{OP_DB2RMS, 32'h0000_0000, 1, 32'd0, 1'b0},
		'{OP_POW2DB, 32'h0100_0000, 1, 32'd100 << 8, 1'b0},   // unity -> 100 dB
		'{OP_RMS2DB, 32'h0100_0000, 1, 32'd100 << 8, 1'b0},
		'{OP_POW2DB, 32'h0000_0001, 0, 0, 0},                 // tiny: rms floors at 0 dB
		'{OP_RMS2DB, 32'h0000_0001, 1, 32'd0, 1'b0},
		'{OP_POW2DB, 32'hFFFF_FFFF, 0, 0, 0},
		'{OP_RMS2DB, 32'hFFFF_FFFF, 0, 0, 0},
		'{OP_DB2POW, 32'd100 << 8, 0, 0, 0},                  // 100 dB -> unity
		'{OP_DB2RMS, 32'd100 << 8, 0, 0, 0},
		'{OP_DB2POW, 32'h0000_0001, 0, 0, 0},                 // tiny linear result
		'{OP_DB2RMS, 32'h0000_0001, 0, 0, 0},
		'{OP_DB2POW, 32'd870 << 8, 1, 32'hFFFF_FFFF, 1'b1},   // clamp, saturate
		'{OP_DB2RMS, 32'd485 << 8, 1, 32'hFFFF_FFFF, 1'b1},
		'{OP_DB2POW, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b1},
		'{OP_DB2RMS, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1'b1},
		'{OP_DB2POW, 32'd124 << 8, 0, 0, 0},                  // near overflow edge
		'{OP_DB2RMS, 32'd148 << 8, 0, 0, 0},
		'{OP_POW2DB, 32'h5555_5555, 0, 0, 0},
		'{OP_RMS2DB, 32'hAAAA_AAAA, 0, 0, 0}
	};

	function automatic req_t pick_request();
		req_t rq;
		int sel;
		rq.op = op_t'($urandom_range(0, 3));
		sel = $urandom_range(0, 9);
		if (rq.op inside {OP_POW2DB, OP_RMS2DB}) begin
			if (sel < 6)
				rq.value = $urandom >> $urandom_range(0, 31);   // spread of magnitudes
			else
				rq.value = $urandom;
		end else begin
			if (sel < 7)
				rq.value = $urandom_range(0, 200 << 8);        // useful dB range
			else if (sel < 9)
				rq.value = $urandom_range(0, 900 << 8);
			else
				rq.value = $urandom;
		end
		return rq;
	endfunction

	// Sender: idle with valid low, then offer one request and hold until accepted.
	task automatic send_request(req_t rq, rsp_t want);
		while ((phase == 0 && $urandom_range(0, 99) < 17) ||
		       (phase == 1 && $urandom_range(0, 99) < 48)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= rq;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		level_q.push_back(want);
	endtask

	// Receiver ready: random stalls per phase, plus a long hold-off.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_ready <= 1'b0;
		end else if (phase == 0) begin
			rsp_ready <= $urandom_range(0, 99) >= 48;
		end else if (phase == 1) begin
			rsp_ready <= $urandom_range(0, 99) >= 17;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Response checker.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (level_q.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected response %h/%b", rsp_data.result,
					         rsp_data.saturated);
				mismatches++;
			end else begin
				want = level_q.pop_front();
				if (want.result !== rsp_data.result ||
				    want.saturated !== rsp_data.saturated) begin
					errors++;
					if (mismatches < 10)
						$display("mismatch: expected %h/%b got %h/%b", want.result,
						         want.saturated, rsp_data.result, rsp_data.saturated);
					mismatches++;
				end
			end
		end
	end

	initial begin
		req_t rq;
		rsp_t want;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			rq.op = dir_rows[i].op;
			rq.value = dir_rows[i].value;
			if (dir_rows[i].use_typed) begin
				want.result    = dir_rows[i].result;
				want.saturated = dir_rows[i].saturated;
			end else begin
				want = convert_level(rq);
			end
			send_request(rq, want);
		end
		for (int i = 0; i < N_RAND; i++) begin
			phase = (i < N_RAND / 3) ? 0 : (i < 2 * N_RAND / 3) ? 1 : 2;
			if (i == N_RAND / 2)
				hold_cycles = 200;   // fill the pipeline and stall the input
			rq = pick_request();
			send_request(rq, convert_level(rq));
		end
		req_valid <= 1'b0;
		while (level_q.size() != 0)
			@(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		if (errors == 0 && level_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

@@ decibel_level_converter.f @@
hdl/dlc_pkg.sv
hdl/decibel_level_converter.sv
verif/decibel_level_converter_test.sv
